@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the elevator order scheduler.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define EOS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define EOS_ASSERT_IMPLY(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

@@ hw/rtl/eos_pkg.sv @@
// Package for the elevator order scheduler: field widths, action and direction codes,
// and the decision type passed from the action logic to the order store. No dependencies.
package eos_pkg;

    localparam int FLOORS_DEF = 4;
    localparam int BUTTONS    = 3;
    localparam int PENDING_W  = 12;
    localparam int MAP_FLOORS_MAX = PENDING_W / BUTTONS;
    localparam int FLOOR_W    = 2;
    localparam int DIR_W      = 2;
    localparam int ACTION_W   = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    typedef logic [BUTTONS-1:0]  order_t;
    typedef logic [FLOOR_W-1:0]  floor_t;
    typedef logic [DIR_W-1:0]    dir_t;
    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_NONE   = 3'd0;
    localparam action_t ACT_DOOR   = 3'd1;
    localparam action_t ACT_STOP   = 3'd2;
    localparam action_t ACT_GROUND = 3'd3;
    localparam action_t ACT_UP     = 3'd4;
    localparam action_t ACT_DOWN   = 3'd5;

    localparam dir_t DIR_DOWN = 2'd0;
    localparam dir_t DIR_STOP = 2'd1;
    localparam dir_t DIR_UP   = 2'd2;

    localparam int BTN_HALL_UP   = 0;
    localparam int BTN_HALL_DOWN = 1;
    localparam int BTN_CAB       = 2;

    typedef struct packed {
        action_t action;
        logic    clear;
        floor_t  floor;
    } decision_t;

endpackage

@@ hw/rtl/eos_orders.sv @@
// Pending-order store of the elevator order scheduler: latches presses, clears a served
// floor and builds the pending bitmap. Depends on eos_pkg.
module eos_orders
    import eos_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [PENDING_W-1:0]    buttons,
    input  decision_t               dec,
    output order_t [FLOORS-1:0]     latched,
    output logic [PENDING_W-1:0]    pending,
    output logic                    any_pending
);

    localparam int MAP_FLOORS = (FLOORS < MAP_FLOORS_MAX) ? FLOORS : MAP_FLOORS_MAX;

    order_t [FLOORS-1:0] store_reg;
    order_t [FLOORS-1:0] store_next;
    order_t [FLOORS-1:0] store_after;

    for (genvar g = 0; g < FLOORS; g++)
    begin : g_latch
        if (g < MAP_FLOORS)
        begin : g_mapped
            assign latched[g] = store_reg[g] | buttons[g*BUTTONS +: BUTTONS];
            assign pending[g*BUTTONS +: BUTTONS] = store_after[g];
        end
        else
        begin : g_unmapped
            assign latched[g] = store_reg[g];
        end
    end

    if (MAP_FLOORS < MAP_FLOORS_MAX)
    begin : g_pad
        assign pending[PENDING_W-1:MAP_FLOORS*BUTTONS] = '0;
    end

    always_comb
    begin
        for (int f = 0; f < FLOORS; f++)
        begin
            if (dec.clear && (32'(dec.floor) == f))
            begin
                store_after[f] = '0;
            end
            else
            begin
                store_after[f] = latched[f];
            end
        end
    end

    assign any_pending = |store_after;
    assign store_next  = advance ? store_after : store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
        end
        else
        begin
            store_reg <= store_next;
        end
    end

endmodule

@@ hw/rtl/eos_decide.sv @@
// Action choice of the elevator order scheduler: no action without a valid floor, stop, door
// service, return to ground or drive direction from the latched orders. Depends on eos_pkg.
module eos_decide
    import eos_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF
)
(
    input  order_t [FLOORS-1:0] orders,
    input  logic                floor_valid,
    input  floor_t              cab_floor,
    input  dir_t                direction,
    input  logic                door_open,
    output decision_t           dec
);

    order_t here;
    logic   above;
    logic   below;
    logic   found;
    logic   in_range;
    logic   stop_here;

    always_comb
    begin
        here  = '0;
        above = 1'b0;
        below = 1'b0;
        found = 1'b0;
        for (int f = 0; f < FLOORS; f++)
        begin
            if (32'(cab_floor) == f)
            begin
                here = orders[f];
            end
            if (orders[f] != '0)
            begin
                found = 1'b1;
                if (f > 32'(cab_floor))
                begin
                    above = 1'b1;
                end
                if (f < 32'(cab_floor))
                begin
                    below = 1'b1;
                end
            end
        end
    end

    assign in_range  = 32'(cab_floor) < FLOORS;
    assign stop_here = here[BTN_CAB]
                    || ((direction == DIR_UP) && here[BTN_HALL_UP])
                    || ((direction == DIR_DOWN) && here[BTN_HALL_DOWN]);

    always_comb
    begin
        dec.floor = cab_floor;
        dec.clear = 1'b0;
        priority if (!floor_valid || !in_range)
        begin
            dec.action = ACT_NONE;
        end
        else if (door_open)
        begin
            dec.action = ACT_DOOR;
        end
        else if (stop_here)
        begin
            dec.action = ACT_STOP;
            dec.clear  = 1'b1;
        end
        else if (!found)
        begin
            dec.action = ACT_GROUND;
        end
        else
        begin
            unique case (direction)
                DIR_DOWN: dec.action = below ? ACT_DOWN : ACT_UP;
                DIR_UP:   dec.action = above ? ACT_UP : ACT_DOWN;
                default:  dec.action = above ? ACT_UP : ACT_DOWN;
            endcase
        end
    end

endmodule

@@ hw/rtl/elevator_order_scheduler.sv @@
// Elevator order scheduler, top level: input register, order store, action logic, result register.
// An accepted input item passes the input register, then the result register, before its result item goes out.
// Throughput is one item per cycle; the only stall is a full result register not being taken.
// Reset clears the order store and both valid flags; depends on eos_pkg, eos_orders, eos_decide.
module elevator_order_scheduler
    import eos_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // buttons_pressed[11:0], floor_valid[12], current_floor[14:13], direction[16:15],
    // door_open[17], zero fill[23:18]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // action[2:0], pending_orders[14:3], any_pending[15]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [PENDING_W-1:0] buttons_reg;
    logic                 floor_valid_reg;
    floor_t               floor_reg;
    dir_t                 dir_reg;
    logic                 door_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    action_t              action_reg;
    logic [PENDING_W-1:0] pending_reg;
    logic                 any_reg;

    logic                 advance;
    logic                 in_take;
    order_t [FLOORS-1:0]  latched;
    logic [PENDING_W-1:0] pending;
    logic                 any_pending;
    decision_t            dec;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            buttons_reg     <= s_axis_tdata[11:0];
            floor_valid_reg <= s_axis_tdata[12];
            floor_reg       <= s_axis_tdata[14:13];
            dir_reg         <= s_axis_tdata[16:15];
            door_reg        <= s_axis_tdata[17];
        end
        if (advance)
        begin
            action_reg  <= dec.action;
            pending_reg <= pending;
            any_reg     <= any_pending;
        end
    end

    eos_orders #(
        .FLOORS (FLOORS)
    ) u_orders (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .buttons     (buttons_reg),
        .dec         (dec),
        .latched     (latched),
        .pending     (pending),
        .any_pending (any_pending)
    );

    eos_decide #(
        .FLOORS (FLOORS)
    ) u_decide (
        .orders      (latched),
        .floor_valid (floor_valid_reg),
        .cab_floor   (floor_reg),
        .direction   (dir_reg),
        .door_open   (door_reg),
        .dec         (dec)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {any_reg, pending_reg, action_reg};

endmodule

@@ hw/rtl/eos_checker.sv @@
// Port-level checker for the elevator order scheduler, bound to the top level.
// Depends on eos_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eos_checker
    import eos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata
);

    `EOS_ASSERT_IMPLY(a_any_matches_map, clk, rst_n, m_axis_tvalid, m_axis_tdata[15] == (m_axis_tdata[14:3] != '0), "any_pending disagrees with the pending bitmap")
    `EOS_ASSERT_IMPLY(a_action_code, clk, rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= ACT_DOWN, "action code out of range")
    `EOS_ASSERT_IMPLY(a_ground_empty, clk, rst_n, m_axis_tvalid && (m_axis_tdata[2:0] == ACT_GROUND), m_axis_tdata[15:3] == '0, "return to ground with orders pending")
    `EOS_ASSERT(a_result_held, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result item changed")

endmodule

bind elevator_order_scheduler eos_checker u_checker (.*);

@@ sim/elevator_order_scheduler_test.sv @@
// Self-checking testbench for the elevator order scheduler: a directed walk through the
// scheduling rules, then random car trips with random idling on both stream sides.
// Depends on eos_pkg and the elevator_order_scheduler RTL only.
module elevator_order_scheduler_test;
    import eos_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAR_FLOORS  = FLOORS_DEF;
    localparam int RANDOM_TICKS = 1530;
    localparam dir_t DIR_UNDEF = 2'd3;

    typedef struct packed {
        action_t              action;
        logic [PENDING_W-1:0] pending;
        logic                 any;
    } tick_result_t;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_EVERY_THIRD, RX_SPARSE} rx_pattern_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [IN_DATA_W-1:0] tick_queue[$];
    tick_result_t         expected_ticks[$];
    order_t               car_orders[CAR_FLOORS];
    logic                 tick_taken = 1'b0;
    int                   ticks_in = 0;
    int                   errors = 0;
    int                   burst_left = 0;
    int                   gap_left = 0;
    bit                   hold_off = 1'b0;
    int                   rx_cycle = 0;
    rx_pattern_t          rx_pattern = RX_ALWAYS;

    elevator_order_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [IN_DATA_W-1:0] pack_tick(input logic [PENDING_W-1:0] buttons,
                                                       input logic valid, input floor_t fl,
                                                       input dir_t dir, input logic door);
        return {{(IN_DATA_W-18){1'b0}}, door, dir, fl, valid, buttons};
    endfunction

    function automatic tick_result_t schedule_tick(input logic [IN_DATA_W-1:0] word);
        logic [PENDING_W-1:0] buttons;
        logic                 valid;
        floor_t               fl;
        dir_t                 dir;
        logic                 door;
        order_t               here;
        int                   lowest;
        int                   highest;
        bit                   seen;
        tick_result_t         res;
        buttons = word[11:0];
        valid   = word[12];
        fl      = word[14:13];
        dir     = word[16:15];
        door    = word[17];
        lowest  = 0;
        highest = 0;
        seen    = 1'b0;
        for (int f = 0; f < CAR_FLOORS; f++)
            if (f * BUTTONS < PENDING_W)
                car_orders[f] = car_orders[f] | buttons[f*BUTTONS +: BUTTONS];
        if (!valid || int'(fl) >= CAR_FLOORS)
            res.action = ACT_NONE;
        else if (door)
            res.action = ACT_DOOR;
        else
        begin
            here = car_orders[fl];
            if (here[BTN_CAB] || (dir == DIR_UP && here[BTN_HALL_UP]) ||
                (dir == DIR_DOWN && here[BTN_HALL_DOWN]))
            begin
                car_orders[fl] = '0;
                res.action = ACT_STOP;
            end
            else
            begin
                for (int f = 0; f < CAR_FLOORS; f++)
                begin
                    if (car_orders[f] != '0)
                    begin
                        if (!seen)
                            lowest = f;
                        highest = f;
                        seen = 1'b1;
                    end
                end
                if (!seen)
                    res.action = ACT_GROUND;
                else if (dir == DIR_UP)
                    res.action = (int'(fl) < highest) ? ACT_UP : ACT_DOWN;
                else if (dir == DIR_DOWN)
                    res.action = (int'(fl) > lowest) ? ACT_DOWN : ACT_UP;
                else
                    res.action = (int'(fl) < highest) ? ACT_UP : ACT_DOWN;
            end
        end
        res.pending = '0;
        res.any     = 1'b0;
        for (int f = 0; f < CAR_FLOORS; f++)
        begin
            if (f * BUTTONS < PENDING_W)
                res.pending[f*BUTTONS +: BUTTONS] = car_orders[f];
            if (car_orders[f] != '0)
                res.any = 1'b1;
        end
        return res;
    endfunction

    // Sender: bursts of items separated by idle gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || tick_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (tick_queue.size() > 0)
            begin
                s_axis_tdata  <= tick_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: a randomly chosen stall pattern, overridden by the long hold-off.
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
        begin
            case (rx_pattern)
                RX_ALWAYS:      m_axis_tready <= 1'b1;
                RX_MOSTLY:      m_axis_tready <= ($urandom_range(0, 9) < 7);
                RX_EVERY_THIRD: m_axis_tready <= (rx_cycle % 3 == 0);
                default:        m_axis_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        tick_result_t want;
        tick_taken <= s_axis_tvalid && s_axis_tready;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_ticks.size() == 0)
            begin
                $error("result item 0x%h arrived with no item outstanding", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_ticks.pop_front();
                if (m_axis_tdata[2:0] !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[14:3] !== want.pending)
                begin
                    $error("pending_orders: expected 0x%h, got 0x%h",
                           want.pending, m_axis_tdata[14:3]);
                    errors++;
                end
                if (m_axis_tdata[15] !== want.any)
                begin
                    $error("any_pending: expected %0d, got %0d", want.any, m_axis_tdata[15]);
                    errors++;
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_ticks.push_back(schedule_tick(s_axis_tdata));
            ticks_in <= ticks_in + 1;
        end
    end

    initial
    begin
        while (ticks_in < 400)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [PENDING_W-1:0] buttons;
        int                   car_floor;
        int                   pick;
        for (int f = 0; f < CAR_FLOORS; f++)
            car_orders[f] = '0;

        // Latching happens even when the floor is unknown; then every floor is served.
        tick_queue.push_back(pack_tick(12'h000, 1'b0, 2'd0, DIR_STOP, 1'b0));
        tick_queue.push_back(pack_tick(12'hFFF, 1'b0, 2'd2, DIR_UP, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd0, DIR_UP, 1'b1));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd0, DIR_UP, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd1, DIR_STOP, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd2, DIR_DOWN, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd3, DIR_UNDEF, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd2, DIR_UP, 1'b0));
        // A hall order at the floor of a stopped car does not stop it; the car drives down.
        tick_queue.push_back(pack_tick(12'h008, 1'b1, 2'd1, DIR_STOP, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd1, DIR_UNDEF, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd1, DIR_DOWN, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd1, DIR_UP, 1'b0));
        tick_queue.push_back(pack_tick(12'h400, 1'b1, 2'd0, DIR_UP, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd3, DIR_DOWN, 1'b0));
        tick_queue.push_back(pack_tick(12'h001, 1'b1, 2'd2, DIR_DOWN, 1'b0));
        tick_queue.push_back(pack_tick(12'h800, 1'b1, 2'd2, DIR_UP, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd2, DIR_STOP, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd3, DIR_UP, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd2, DIR_UP, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd0, DIR_DOWN, 1'b0));
        tick_queue.push_back(pack_tick(12'h000, 1'b1, 2'd0, DIR_UP, 1'b0));
        tick_queue.push_back(pack_tick(12'h555, 1'b0, 2'd1, DIR_DOWN, 1'b1));
        tick_queue.push_back(pack_tick(12'hAAA, 1'b1, 2'd3, DIR_STOP, 1'b1));

        // Random trips: the car walks between neighbouring floors while presses trickle in.
        car_floor = 0;
        for (int n = 0; n < RANDOM_TICKS; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                buttons = '0;
            else if (pick < 9)
                buttons = 12'h001 << $urandom_range(0, PENDING_W - 1);
            else
                buttons = PENDING_W'($urandom_range(0, 12'hFFF));
            pick = $urandom_range(0, 2);
            if (pick == 0 && car_floor > 0)
                car_floor--;
            else if (pick == 2 && car_floor < CAR_FLOORS - 1)
                car_floor++;
            tick_queue.push_back(pack_tick(buttons, $urandom_range(0, 9) != 0,
                                           floor_t'(car_floor), dir_t'($urandom_range(0, 3)),
                                           $urandom_range(0, 6) == 0));
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (tick_queue.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_ticks.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_ticks.size() > 0 || m_axis_tvalid)
        begin
            $error("results left over or unexpected result item at the end");
            errors++;
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
